@@ rtl/mbet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, register indexes, control bundles and the saturation helper.
// ----------------------------------------------------------------------------
package mbet_pkg;

	localparam int FRAC_BITS  = 26;
	localparam int COORD_BITS = 12;
	localparam int ITER_BITS  = 10;
	localparam int WORD_W     = 32;
	localparam int WIDTH_W    = 13;
	localparam int INDEX_W    = 24;
	localparam int PROD_W     = 2 * WORD_W;
	localparam int CPROD_W    = COORD_BITS + 1 + WORD_W;
	localparam int WIDE_W     = 48;
	localparam int IDXPROD_W  = COORD_BITS + WIDTH_W;
	localparam int REG_IDX_W  = 3;

	// Escape bound 2*2 = 4 expressed in the squared fraction format.
	localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(2 * 2) << (2 * FRAC_BITS);

	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_RE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_IM = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP_RE   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP_IM   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_IMG_WIDTH = 3'd5;

	localparam logic signed [WORD_W-1:0] RST_ORIGIN_RE = -32'sd134217728;
	localparam logic signed [WORD_W-1:0] RST_ORIGIN_IM = -32'sd100663296;
	localparam logic signed [WORD_W-1:0] RST_STEP_RE   = 32'sd196608;
	localparam logic signed [WORD_W-1:0] RST_STEP_IM   = 32'sd196608;
	localparam logic [ITER_BITS-1:0]     RST_MAX_ITER  = 10'd255;
	localparam logic [WIDTH_W-1:0]       RST_IMG_WIDTH = 13'd1024;

	typedef struct packed {
		logic signed [WORD_W-1:0] origin_re;
		logic signed [WORD_W-1:0] origin_im;
		logic signed [WORD_W-1:0] step_re;
		logic signed [WORD_W-1:0] step_im;
		logic [ITER_BITS-1:0]     max_iterations;
		logic [WIDTH_W-1:0]       image_width;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic calc_c;
		logic set_c;
		logic mul;
		logic step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic escaped;
		logic at_limit;
	} dp_sts_t;

	// Clamp a wide signed value to the signed word range.
	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-WORD_W:0] top;
		begin
			top = v[WIDE_W-1:WORD_W-1];
			if (&top || ~|top) begin
				return v[WORD_W-1:0];
			end else if (v[WIDE_W-1]) begin
				return {1'b1, {(WORD_W-1){1'b0}}};
			end else begin
				return {1'b0, {(WORD_W-1){1'b1}}};
			end
		end
	endfunction

endpackage

@@ rtl/mbet_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot configuration registers
// Holds the view window, iteration limit and image width written by the host.
// ----------------------------------------------------------------------------
module mbet_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mbet_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [mbet_pkg::WORD_W-1:0]      cfg_data,
	output mbet_pkg::cfg_t                   cfg
);
	import mbet_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_re      <= RST_ORIGIN_RE;
			cfg_q.origin_im      <= RST_ORIGIN_IM;
			cfg_q.step_re        <= RST_STEP_RE;
			cfg_q.step_im        <= RST_STEP_IM;
			cfg_q.max_iterations <= RST_MAX_ITER;
			cfg_q.image_width    <= RST_IMG_WIDTH;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ORIGIN_RE: cfg_q.origin_re      <= cfg_data;
				REG_ORIGIN_IM: cfg_q.origin_im      <= cfg_data;
				REG_STEP_RE:   cfg_q.step_re        <= cfg_data;
				REG_STEP_IM:   cfg_q.step_im        <= cfg_data;
				REG_MAX_ITER:  cfg_q.max_iterations <= cfg_data[ITER_BITS-1:0];
				REG_IMG_WIDTH: cfg_q.image_width    <= cfg_data[WIDTH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/mbet_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot datapath
// Point mapping, the z = z*z + c recurrence and the result register.
// ----------------------------------------------------------------------------
module mbet_dp (
	input  logic                              clk,
	input  mbet_pkg::cfg_t                    cfg,
	input  mbet_pkg::dp_cmd_t                 cmd,
	output mbet_pkg::dp_sts_t                 sts,
	input  logic [mbet_pkg::COORD_BITS-1:0]   pixel_x,
	input  logic [mbet_pkg::COORD_BITS-1:0]   pixel_y,
	output logic [mbet_pkg::ITER_BITS-1:0]    iteration_count,
	output logic                              inside_set,
	output logic [mbet_pkg::INDEX_W-1:0]      pixel_index
);
	import mbet_pkg::*;

	logic [COORD_BITS-1:0]      px_q;
	logic [COORD_BITS-1:0]      py_q;
	logic signed [CPROD_W-1:0]  cr_prod_s1;
	logic signed [CPROD_W-1:0]  ci_prod_s1;
	logic [IDXPROD_W-1:0]       idx_prod_s1;
	logic signed [WORD_W-1:0]   cr_q;
	logic signed [WORD_W-1:0]   ci_q;
	logic [INDEX_W-1:0]         idx_q;
	logic signed [WORD_W-1:0]   zr_q;
	logic signed [WORD_W-1:0]   zi_q;
	logic [ITER_BITS-1:0]       iter_q;
	logic signed [PROD_W-1:0]   rr_s1;
	logic signed [PROD_W-1:0]   ii_s1;
	logic signed [PROD_W-1:0]   ri_s1;
	logic [ITER_BITS-1:0]       count_q;
	logic                       inside_q;
	logic [INDEX_W-1:0]         index_q;

	logic [PROD_W-1:0]          mag2;
	logic signed [PROD_W-1:0]   diff;
	logic signed [WIDE_W-1:0]   cr_sum;
	logic signed [WIDE_W-1:0]   ci_sum;
	logic signed [WIDE_W-1:0]   nr_sum;
	logic signed [WIDE_W-1:0]   ni_sum;
	logic [IDXPROD_W-1:0]       idx_sum;

	always_comb begin
		cr_sum  = WIDE_W'(cfg.origin_re) + WIDE_W'(cr_prod_s1);
		ci_sum  = WIDE_W'(cfg.origin_im) + WIDE_W'(ci_prod_s1);
		idx_sum = idx_prod_s1 + IDXPROD_W'(px_q);
		mag2    = PROD_W'(rr_s1) + PROD_W'(ii_s1);
		diff    = rr_s1 - ii_s1;
		// Floor division by a power of two is an arithmetic shift; the cross
		// product is doubled by shifting one place less.
		nr_sum  = WIDE_W'($signed(diff[PROD_W-1:FRAC_BITS])) + WIDE_W'(cr_q);
		ni_sum  = WIDE_W'($signed(ri_s1[PROD_W-1:FRAC_BITS-1])) + WIDE_W'(ci_q);
	end

	assign sts.escaped  = (mag2 >= ESC_LIMIT);
	assign sts.at_limit = (iter_q >= cfg.max_iterations);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		if (cmd.calc_c) begin
			cr_prod_s1  <= CPROD_W'($signed({1'b0, px_q})) * CPROD_W'(cfg.step_re);
			ci_prod_s1  <= CPROD_W'($signed({1'b0, py_q})) * CPROD_W'(cfg.step_im);
			idx_prod_s1 <= IDXPROD_W'(py_q) * IDXPROD_W'(cfg.image_width);
		end
		if (cmd.set_c) begin
			cr_q   <= sat_word(cr_sum);
			ci_q   <= sat_word(ci_sum);
			idx_q  <= idx_sum[INDEX_W-1:0];
			zr_q   <= '0;
			zi_q   <= '0;
			iter_q <= '0;
		end else if (cmd.step) begin
			zr_q   <= sat_word(nr_sum);
			zi_q   <= sat_word(ni_sum);
			iter_q <= iter_q + 1'b1;
		end
		if (cmd.mul) begin
			rr_s1 <= PROD_W'(zr_q) * PROD_W'(zr_q);
			ii_s1 <= PROD_W'(zi_q) * PROD_W'(zi_q);
			ri_s1 <= PROD_W'(zr_q) * PROD_W'(zi_q);
		end
		if (cmd.load_out) begin
			count_q  <= iter_q;
			inside_q <= (iter_q == cfg.max_iterations);
			index_q  <= idx_q;
		end
	end

	assign iteration_count = count_q;
	assign inside_set      = inside_q;
	assign pixel_index     = index_q;

endmodule

@@ rtl/mbet_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot controller
// Sequences point mapping, the multiply and update steps, and result hand-off.
// ----------------------------------------------------------------------------
module mbet_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  mbet_pkg::dp_sts_t     sts,
	output mbet_pkg::dp_cmd_t     cmd
);
	import mbet_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMUL = 3'd1;
	localparam logic [2:0] ST_CSET = 3'd2;
	localparam logic [2:0] ST_ZMUL = 3'd3;
	localparam logic [2:0] ST_ZCHK = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = ST_CMUL;
				end
			end
			ST_CMUL: begin
				cmd.calc_c = 1'b1;
				state_d    = ST_CSET;
			end
			ST_CSET: begin
				cmd.set_c = 1'b1;
				state_d   = ST_ZMUL;
			end
			ST_ZMUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ZCHK;
			end
			ST_ZCHK: begin
				if (sts.escaped || sts.at_limit) begin
					state_d = ST_FIN;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_ZMUL;
				end
			end
			ST_FIN: begin
				// Wait until the result register is empty or drains this cycle.
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ rtl/mandelbrot_escape_time_unit.sv @@
`timescale 1ns / 1ps
// A pixel beat is loaded, mapped to c with z cleared, and iterated until escape or max_iterations.
// Each iteration is a multiply step on three 32x32 multipliers followed by an update and
// escape-check step; the next pixel beat is taken only after the result is loaded out.
// A result waiting in the output register does not block the next input beat.
// Reset (arst_n low, asynchronous) empties the block and restores the default view window.
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Maps a pixel to a complex point and counts iterations until escape.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mbet_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [mbet_pkg::WORD_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mbet_pkg::COORD_BITS-1:0]  pixel_x,
	input  logic [mbet_pkg::COORD_BITS-1:0]  pixel_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mbet_pkg::ITER_BITS-1:0]   iteration_count,
	output logic                             inside_set,
	output logic [mbet_pkg::INDEX_W-1:0]     pixel_index
);
	import mbet_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	mbet_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mbet_dp u_dp (
		.clk             (clk),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.iteration_count (iteration_count),
		.inside_set      (inside_set),
		.pixel_index     (pixel_index)
	);

endmodule

@@ tb/sv/escape_time_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time checker
// Follows register writes, predicts the escape result of every accepted pixel
// beat and compares each output beat with the oldest prediction in line.
// ----------------------------------------------------------------------------
module escape_time_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mbet_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [mbet_pkg::WORD_W-1:0]      cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [mbet_pkg::COORD_BITS-1:0]  pixel_x,
	input  logic [mbet_pkg::COORD_BITS-1:0]  pixel_y,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [mbet_pkg::ITER_BITS-1:0]   iteration_count,
	input  logic                             inside_set,
	input  logic [mbet_pkg::INDEX_W-1:0]     pixel_index,
	output int                               mismatch_total,
	output int                               pixels_in_flight
);

	import mbet_pkg::*;

	typedef struct packed {
		logic [ITER_BITS-1:0] count;
		logic                 in_set;
		logic [INDEX_W-1:0]   index;
	} pixel_result_t;

	// |z|^2 >= 4 in the squared format, where products carry twice the fraction bits.
	localparam longint unsigned ESCAPE_BOUND = 64'd4 << (2 * FRAC_BITS);
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;

	cfg_t          view;
	pixel_result_t expected_pixels[$];
	int            errors;

	function automatic longint clamp_word(input longint v);
		if (v > WORD_MAX) begin
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			return WORD_MIN;
		end
		return v;
	endfunction

	function automatic pixel_result_t escape_time_of(input cfg_t v,
			input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
		longint          c_re, c_im, z_re, z_im, re_sq, im_sq, next_re, next_im, lin;
		longint unsigned mag;
		int unsigned     n;
		bit              done;
		pixel_result_t   r;
		c_re = clamp_word(longint'($signed(v.origin_re)) +
			longint'(px) * longint'($signed(v.step_re)));
		c_im = clamp_word(longint'($signed(v.origin_im)) +
			longint'(py) * longint'($signed(v.step_im)));
		z_re = 0;
		z_im = 0;
		n = 0;
		done = 1'b0;
		while (!done) begin
			re_sq = z_re * z_re;
			im_sq = z_im * z_im;
			mag = longint'(unsigned'(re_sq)) + longint'(unsigned'(im_sq));
			if (mag >= ESCAPE_BOUND || n >= v.max_iterations) begin
				done = 1'b1;
			end else begin
				// Arithmetic shifts floor toward minus infinity, as the datapath does.
				next_re = clamp_word(((re_sq - im_sq) >>> FRAC_BITS) + c_re);
				next_im = clamp_word(((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im);
				z_re = next_re;
				z_im = next_im;
				n++;
			end
		end
		lin = longint'(px) + longint'(py) * longint'(v.image_width);
		r.count  = n[ITER_BITS-1:0];
		r.in_set = (n == v.max_iterations);
		r.index  = lin[INDEX_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t seen;
		pixel_result_t want;
		if (!arst_n) begin
			view.origin_re      = RST_ORIGIN_RE;
			view.origin_im      = RST_ORIGIN_IM;
			view.step_re        = RST_STEP_RE;
			view.step_im        = RST_STEP_IM;
			view.max_iterations = RST_MAX_ITER;
			view.image_width    = RST_IMG_WIDTH;
			expected_pixels.delete();
			errors = 0;
			mismatch_total   <= 0;
			pixels_in_flight <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ORIGIN_RE: view.origin_re      = cfg_data;
					REG_ORIGIN_IM: view.origin_im      = cfg_data;
					REG_STEP_RE:   view.step_re        = cfg_data;
					REG_STEP_IM:   view.step_im        = cfg_data;
					REG_MAX_ITER:  view.max_iterations = cfg_data[ITER_BITS-1:0];
					REG_IMG_WIDTH: view.image_width    = cfg_data[WIDTH_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				expected_pixels.push_back(escape_time_of(view, pixel_x, pixel_y));
			end
			if (out_valid && out_ready) begin
				seen = {iteration_count, inside_set, pixel_index};
				if (expected_pixels.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: result beat with nothing pending: count %0d inside %0d index %0d",
							$realtime, seen.count, seen.in_set, seen.index);
					end
				end else begin
					want = expected_pixels.pop_front();
					if (seen != want) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch count %0d/%0d inside %0d/%0d index %0d/%0d (exp/got)",
								$realtime, want.count, seen.count, want.in_set, seen.in_set,
								want.index, seen.index);
						end
					end
				end
			end
			mismatch_total   <= errors;
			pixels_in_flight <= expected_pixels.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time testbench
// Drives pixel beats and register writes into the unit through directed views
// and randomized phases, with random idling on both channels, and reports the
// verdict from the checker's mismatch and in-flight counts.
// ----------------------------------------------------------------------------
module testbench;

	import mbet_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int Q_ONE            = 1 << FRAC_BITS;
	localparam int RANDOM_PHASES    = 15;
	localparam int PIXELS_PER_PHASE = 60;
	localparam int DEEP_PHASE       = 7;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [REG_IDX_W-1:0]   cfg_index;
	logic [WORD_W-1:0]      cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [COORD_BITS-1:0]  pixel_x;
	logic [COORD_BITS-1:0]  pixel_y;
	logic                   out_valid;
	logic                   out_ready;
	logic [ITER_BITS-1:0]   iteration_count;
	logic                   inside_set;
	logic [INDEX_W-1:0]     pixel_index;
	int                     mismatch_total;
	int                     pixels_in_flight;
	int                     gap_pct;
	int                     stall_pct;

	mandelbrot_escape_time_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.iteration_count (iteration_count),
		.inside_set      (inside_set),
		.pixel_index     (pixel_index)
	);

	escape_time_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.iteration_count  (iteration_count),
		.inside_set       (inside_set),
		.pixel_index      (pixel_index),
		.mismatch_total   (mismatch_total),
		.pixels_in_flight (pixels_in_flight)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x  <= x;
		pixel_y  <= y;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Registers may only change once every pending pixel has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		#100_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int kind;
		int beats;
		int ore, oim, sre, sim, lim, wid;
		gap_pct   = 0;
		stall_pct = 0;
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		pixel_x   <= '0;
		pixel_y   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset view: the corners, a point near zero that stays inside, and c = -2,
		// which sits exactly on the escape circle.
		gap_pct   = 15;
		stall_pct = 10;
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(4095, 0);
		send_pixel(0, 4095);
		send_pixel(683, 512);
		send_pixel(0, 512);
		wait_idle();

		// Extreme registers: c saturates both ways and the linear index wraps.
		write_reg(REG_ORIGIN_RE, 32'h7FFF_FFFF);
		write_reg(REG_STEP_RE, 32'h7FFF_FFFF);
		write_reg(REG_ORIGIN_IM, 32'h8000_0000);
		write_reg(REG_STEP_IM, 32'h8000_0000);
		write_reg(REG_MAX_ITER, 32'hFFFF_FFFF);
		write_reg(REG_IMG_WIDTH, 32'hFFFF_FFFF);
		send_pixel(4095, 4095);
		send_pixel(0, 0);
		send_pixel(1, 1);
		wait_idle();

		// Writes to unused indexes must leave every register alone.
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_SPARE_HI, $urandom);
		send_pixel(1, 4095);
		send_pixel(4095, 1);
		wait_idle();

		// A zero limit does no step at all; a zero width leaves only the column.
		write_reg(REG_MAX_ITER, 32'hFFFF_FC00);
		write_reg(REG_IMG_WIDTH, 32'hFFFF_E000);
		send_pixel(123, 4095);
		send_pixel(4095, 0);
		wait_idle();

		write_reg(REG_ORIGIN_RE, 0);
		write_reg(REG_ORIGIN_IM, 0);
		write_reg(REG_STEP_RE, 0);
		write_reg(REG_STEP_IM, 0);
		write_reg(REG_MAX_ITER, 1);
		write_reg(REG_IMG_WIDTH, 1);
		send_pixel(77, 3000);
		send_pixel(4095, 4095);
		wait_idle();

		// Full limit: the period-two orbit at -1, the cusp at 0.25, zero, and the
		// points 2 and 2i on the escape circle.
		write_reg(REG_ORIGIN_RE, -Q_ONE);
		write_reg(REG_STEP_RE, Q_ONE / 4);
		write_reg(REG_ORIGIN_IM, 0);
		write_reg(REG_STEP_IM, Q_ONE);
		write_reg(REG_MAX_ITER, 1023);
		write_reg(REG_IMG_WIDTH, 4096);
		send_pixel(0, 0);
		send_pixel(5, 0);
		send_pixel(12, 0);
		send_pixel(4, 2);
		send_pixel(4, 0);
		wait_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			kind = (phase == DEEP_PHASE) ? 10 : $urandom_range(0, 9);
			case ($urandom_range(0, 2))
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 15; stall_pct = 5;  end
				default: begin gap_pct = 40; stall_pct = 20; end
			endcase
			if (phase >= RANDOM_PHASES - 2) begin
				gap_pct   = 0;
				stall_pct = 0;
			end

			ore = -5 * Q_ONE / 2 + int'($urandom_range(0, 7 * Q_ONE / 2));
			oim = -2 * Q_ONE + int'($urandom_range(0, 2 * Q_ONE));
			sre = $urandom_range(1, 98304);
			sim = $urandom_range(1, 98304);
			lim = $urandom_range(1, 48);
			if (kind == 5 || kind == 6 || kind == 10) begin
				// Zoomed windows land mostly near or inside the set.
				ore = (kind == 10) ? -3 * Q_ONE / 4 + int'($urandom_range(0, Q_ONE / 2))
					: -2 * Q_ONE + int'($urandom_range(0, 5 * Q_ONE / 2));
				oim = -Q_ONE / 2 + int'($urandom_range(0, Q_ONE));
				sre = $urandom_range(1, 4096);
				sim = $urandom_range(1, 4096);
				lim = (kind == 10) ? $urandom_range(512, 1023) : $urandom_range(16, 96);
			end else if (kind == 7) begin
				lim = $urandom_range(0, 2);
			end
			if ($urandom_range(0, 7) == 0) sre = -sre;
			if ($urandom_range(0, 7) == 0) sim = -sim;
			case ($urandom_range(0, 3))
				0: wid = $urandom_range(0, 8191);
				1: wid = 4096;
				2: wid = $urandom_range(1, 64);
				default: wid = $urandom_range(0, 1) ? 8191 : 0;
			endcase

			if (kind == 8 || kind == 9) begin
				write_reg(REG_ORIGIN_RE, $urandom);
				write_reg(REG_ORIGIN_IM, $urandom);
				write_reg(REG_STEP_RE, $urandom);
				write_reg(REG_STEP_IM, $urandom);
				write_reg(REG_MAX_ITER, $urandom);
				write_reg(REG_IMG_WIDTH, $urandom);
			end else begin
				write_reg(REG_ORIGIN_RE, ore);
				write_reg(REG_ORIGIN_IM, oim);
				write_reg(REG_STEP_RE, sre);
				write_reg(REG_STEP_IM, sim);
				// Upper data bits above the register width must be dropped.
				write_reg(REG_MAX_ITER, ($urandom & ~32'h3FF) | lim);
				write_reg(REG_IMG_WIDTH, ($urandom & ~32'h1FFF) | wid);
			end

			beats = (kind == 10) ? 6 : PIXELS_PER_PHASE;
			for (int k = 0; k < beats; k++) begin
				send_pixel(COORD_BITS'($urandom_range(0, 4095)),
					COORD_BITS'($urandom_range(0, 4095)));
			end
			wait_idle();
		end

		repeat (64) @(posedge clk);
		if (mismatch_total == 0 && pixels_in_flight == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
